// ===== sv/rgbw_pkg.sv =====
package rgbw_pkg;

	localparam int unsigned TBL_DEPTH = 256;
	localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 4 * BYTE_W;

	// luma weights, Q0.16, sum is exactly 65536
	localparam int unsigned LUMA_FRAC = 16;
	localparam int unsigned LUMA_SUM_W = LUMA_FRAC + BYTE_W;
	localparam logic [LUMA_FRAC:0] LUMA_WT_R = 17'd19595;
	localparam logic [LUMA_FRAC:0] LUMA_WT_G = 17'd38470;
	localparam logic [LUMA_FRAC:0] LUMA_WT_B = 17'd7471;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [TBL_AW-1:0] addr_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic {
		FUNC_WRITE   = 1'b0,
		FUNC_CONVERT = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		TBL_RED   = 2'd0,
		TBL_GREEN = 2'd1,
		TBL_BLUE  = 2'd2,
		TBL_WHITE = 2'd3
	} tbl_sel_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
		logic white;
	} tbl_we_t;

endpackage

// ===== sv/rgbw_if.sv =====
interface rgbw_in_if;
	logic             valid;
	logic             ready;
	rgbw_pkg::func_t  func;
	logic [1:0]       table_select;
	logic [7:0]       entry_index;
	logic [7:0]       entry_value;
	logic [7:0]       red_in;
	logic [7:0]       green_in;
	logic [7:0]       blue_in;
	logic             sample_valid;

	modport source (
		output valid, func, table_select, entry_index, entry_value,
		output red_in, green_in, blue_in, sample_valid,
		input  ready
	);
	modport sink (
		input  valid, func, table_select, entry_index, entry_value,
		input  red_in, green_in, blue_in, sample_valid,
		output ready
	);
endinterface

interface rgbw_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] led_word;

	modport source (output valid, led_word, input ready);
	modport sink (input valid, led_word, output ready);
endinterface

// ===== sv/rgb_to_rgbw_gamma_packer.sv =====
// RGB to RGBW gamma packer. Each beat on req either writes one entry of the red,
// green, blue or white gamma table (func write) or converts one pixel (func
// convert); only converts give a beat on rsp. A convert maps R, G, B through
// their tables and looks up white at luma = (19595 R + 38470 G + 7471 B) >> 16;
// the word is packed G, R, B, W from bit 0 up, and is zero for an invalid
// sample. One beat is taken every clock while rsp keeps up; each request passes
// the input register, the color table reads with the luma multiply, then the
// white table read, whose registered output is the result register. Table
// entries must be written before they are read.
module rgb_to_rgbw_gamma_packer (
	input logic        clk,
	input logic        arst_n,
	rgbw_in_if.sink    req,
	rgbw_out_if.source rsp
);

	// stage 1: input register
	logic                     v_s1;
	rgbw_pkg::func_t          func_s1;
	rgbw_pkg::tbl_sel_t       sel_s1;
	rgbw_pkg::addr_t          idx_s1;
	rgbw_pkg::byte_t          val_s1;
	rgbw_pkg::byte_t          red_s1;
	rgbw_pkg::byte_t          green_s1;
	rgbw_pkg::byte_t          blue_s1;
	logic                     smp_s1;

	// stage 2: color lookups and luma
	logic                     v_s2;
	logic                     conv_s2;
	logic                     live_s2;
	rgbw_pkg::byte_t          luma_s2;
	rgbw_pkg::byte_t          red_s2;
	rgbw_pkg::byte_t          green_s2;
	rgbw_pkg::byte_t          blue_s2;

	// stage 3: result register
	logic                     v_s3;
	rgbw_pkg::byte_t          red_s3;
	rgbw_pkg::byte_t          green_s3;
	rgbw_pkg::byte_t          blue_s3;
	rgbw_pkg::byte_t          white_s3;

	logic                     ld1;
	logic                     ld2;
	logic                     ld3;
	logic                     adv1;
	logic                     live_s1;
	rgbw_pkg::byte_t          luma_s1;
	rgbw_pkg::tbl_we_t        we;

	assign ld3  = !v_s3 || rsp.ready;
	assign ld2  = !v_s2 || ld3;
	assign ld1  = !v_s1 || ld2;
	assign adv1 = v_s1 && ld2;

	assign req.ready = ld1;

	assign live_s1 = (func_s1 == rgbw_pkg::FUNC_CONVERT) && smp_s1;

	always_comb begin
		we       = '0;
		if (adv1 && func_s1 == rgbw_pkg::FUNC_WRITE) begin
			case (sel_s1)
				rgbw_pkg::TBL_RED:   we.red   = 1'b1;
				rgbw_pkg::TBL_GREEN: we.green = 1'b1;
				rgbw_pkg::TBL_BLUE:  we.blue  = 1'b1;
				rgbw_pkg::TBL_WHITE: we.white = 1'b1;
				default:             we       = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= req.valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2 && conv_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			func_s1  <= req.func;
			sel_s1   <= rgbw_pkg::tbl_sel_t'(req.table_select);
			idx_s1   <= req.entry_index;
			val_s1   <= req.entry_value;
			red_s1   <= req.red_in;
			green_s1 <= req.green_in;
			blue_s1  <= req.blue_in;
			smp_s1   <= req.sample_valid;
		end
		if (ld2) begin
			conv_s2 <= (func_s1 == rgbw_pkg::FUNC_CONVERT);
			live_s2 <= live_s1;
			luma_s2 <= luma_s1;
		end
		if (ld3) begin
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
		end
	end

	rgbw_luma u_luma (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.luma  (luma_s1)
	);

	rgbw_table u_tbl_red (
		.clk     (clk),
		.wr_en   (we.red),
		.wr_addr (idx_s1),
		.wr_data (val_s1),
		.rd_en   (ld2),
		.rd_clr  (!live_s1),
		.rd_addr (red_s1),
		.rd_data (red_s2)
	);

	rgbw_table u_tbl_green (
		.clk     (clk),
		.wr_en   (we.green),
		.wr_addr (idx_s1),
		.wr_data (val_s1),
		.rd_en   (ld2),
		.rd_clr  (!live_s1),
		.rd_addr (green_s1),
		.rd_data (green_s2)
	);

	rgbw_table u_tbl_blue (
		.clk     (clk),
		.wr_en   (we.blue),
		.wr_addr (idx_s1),
		.wr_data (val_s1),
		.rd_en   (ld2),
		.rd_clr  (!live_s1),
		.rd_addr (blue_s1),
		.rd_data (blue_s2)
	);

	// white is read one stage later; a younger write in stage 1 only lands
	// on the same edge, so the read still sees the older contents
	rgbw_table u_tbl_white (
		.clk     (clk),
		.wr_en   (we.white),
		.wr_addr (idx_s1),
		.wr_data (val_s1),
		.rd_en   (ld3),
		.rd_clr  (!live_s2),
		.rd_addr (luma_s2),
		.rd_data (white_s3)
	);

	assign rsp.valid    = v_s3;
	assign rsp.led_word = {white_s3, blue_s3, red_s3, green_s3};

	a_one_table_written: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(we))
		else $error("more than one gamma table written in one cycle");

	a_write_waits_for_white_read: assert property (@(posedge clk) disable iff (!arst_n)
		(we != '0) |-> (!v_s2 || ld3))
		else $error("table write overtook a pending white lookup");

	a_dead_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ld3 && v_s2 && !conv_s2) |=> !v_s3)
		else $error("write beat left stage 3 marked valid");

	a_invalid_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && func_s1 == rgbw_pkg::FUNC_CONVERT && !smp_s1)
		|=> (red_s2 == '0 && green_s2 == '0 && blue_s2 == '0))
		else $error("invalid sample produced nonzero color bytes");

endmodule

// ===== sv/rgbw_table.sv =====
module rgbw_table (
	input  logic            clk,
	input  logic            wr_en,
	input  rgbw_pkg::addr_t wr_addr,
	input  rgbw_pkg::byte_t wr_data,
	input  logic            rd_en,
	input  logic            rd_clr,
	input  rgbw_pkg::addr_t rd_addr,
	output rgbw_pkg::byte_t rd_data
);

	rgbw_pkg::byte_t mem [rgbw_pkg::TBL_DEPTH];
	rgbw_pkg::byte_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rd_clr ? '0 : mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/rgbw_luma.sv =====
module rgbw_luma (
	input  rgbw_pkg::byte_t red,
	input  rgbw_pkg::byte_t green,
	input  rgbw_pkg::byte_t blue,
	output rgbw_pkg::byte_t luma
);

	logic [rgbw_pkg::LUMA_SUM_W-1:0] prod_r;
	logic [rgbw_pkg::LUMA_SUM_W-1:0] prod_g;
	logic [rgbw_pkg::LUMA_SUM_W-1:0] prod_b;
	logic [rgbw_pkg::LUMA_SUM_W-1:0] sum;

	always_comb begin
		prod_r = rgbw_pkg::LUMA_SUM_W'(rgbw_pkg::LUMA_WT_R * red);
		prod_g = rgbw_pkg::LUMA_SUM_W'(rgbw_pkg::LUMA_WT_G * green);
		prod_b = rgbw_pkg::LUMA_SUM_W'(rgbw_pkg::LUMA_WT_B * blue);
		// weights sum to 1.0, so the total never exceeds 255 << 16
		sum    = prod_r + prod_g + prod_b;
		luma   = sum[rgbw_pkg::LUMA_SUM_W-1:rgbw_pkg::LUMA_FRAC];
	end

endmodule

// ===== sim/rgb_to_rgbw_gamma_packer_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_rgbw_gamma_packer_tb;

	localparam int RESET_CYCLES    = 8;
	localparam int RANDOM_ITEMS    = 900;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int DIR_ROWS        = 23;

	localparam rgbw_pkg::func_t    F_WR  = rgbw_pkg::FUNC_WRITE;
	localparam rgbw_pkg::func_t    F_CV  = rgbw_pkg::FUNC_CONVERT;
	localparam rgbw_pkg::tbl_sel_t T_RED = rgbw_pkg::TBL_RED;
	localparam rgbw_pkg::tbl_sel_t T_GRN = rgbw_pkg::TBL_GREEN;
	localparam rgbw_pkg::tbl_sel_t T_BLU = rgbw_pkg::TBL_BLUE;
	localparam rgbw_pkg::tbl_sel_t T_WHT = rgbw_pkg::TBL_WHITE;

	typedef enum int {
		PH_SEND_SLOW,
		PH_RECV_SLOW,
		PH_FULL_RATE
	} idle_phase_t;

	typedef struct {
		rgbw_pkg::func_t    func;
		rgbw_pkg::tbl_sel_t sel;
		rgbw_pkg::byte_t    idx;
		rgbw_pkg::byte_t    val;
		rgbw_pkg::byte_t    red;
		rgbw_pkg::byte_t    green;
		rgbw_pkg::byte_t    blue;
		logic               sample_ok;
	} led_cmd_t;

	typedef struct {
		rgbw_pkg::func_t    func;
		rgbw_pkg::tbl_sel_t sel;
		rgbw_pkg::byte_t    idx;
		rgbw_pkg::byte_t    val;
		rgbw_pkg::byte_t    red;
		rgbw_pkg::byte_t    green;
		rgbw_pkg::byte_t    blue;
		logic               sample_ok;
		bit                 typed;
		rgbw_pkg::word_t    word;
	} directed_row_t;

	logic clk;
	logic arst_n;

	rgbw_in_if  pix_in ();
	rgbw_out_if led_out ();

	rgb_to_rgbw_gamma_packer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pix_in),
		.rsp    (led_out)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// gamma lookup state as the block should hold it
	rgbw_pkg::byte_t gamma_lut [4][256];
	bit              lut_loaded [4][256];
	rgbw_pkg::word_t pending_words [$];

	idle_phase_t idle_phase;
	bit          hold_off_req;
	bit          hold_off_done;
	int          fail_count;
	int          issued_cmds;
	int          write_beats;
	int          convert_beats;
	int          blank_beats;
	int          checked_words;

	directed_row_t directed_rows [DIR_ROWS] = '{
		'{F_WR, T_RED, 8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_WR, T_GRN, 8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_WR, T_BLU, 8'h00, 8'h33, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_WR, T_WHT, 8'h00, 8'h44, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_WR, T_RED, 8'hFF, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 32'h0},
		'{F_WR, T_GRN, 8'hFF, 8'hBB, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 32'h0},
		'{F_WR, T_BLU, 8'hFF, 8'hCC, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 32'h0},
		'{F_WR, T_WHT, 8'hFF, 8'hDD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 32'h0},
		'{F_CV, T_WHT, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 32'h44331122},
		'{F_CV, T_RED, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 32'hDDCCAABB},
		'{F_CV, T_WHT, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 32'h0},
		'{F_CV, T_RED, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 32'h0},
		'{F_WR, T_WHT, 8'd76,  8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_CV, T_RED, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 32'h0},
		'{F_WR, T_WHT, 8'd149, 8'h5A, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_CV, T_RED, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 32'h0},
		'{F_WR, T_WHT, 8'd29,  8'hA5, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_CV, T_RED, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 32'h0},
		'{F_WR, T_GRN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_CV, T_RED, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 32'h44331100},
		'{F_WR, T_RED, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_WR, T_WHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 32'h0},
		'{F_CV, T_BLU, 8'h5A, 8'hA5, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 32'h0033FF00}
	};

	// truncated Q0.16 luma; weights sum to 65536 so the top byte never overflows
	function automatic rgbw_pkg::byte_t luma_of(rgbw_pkg::byte_t r, rgbw_pkg::byte_t g,
	                                            rgbw_pkg::byte_t b);
		logic [23:0] acc;
		acc = 24'd19595 * r + 24'd38470 * g + 24'd7471 * b;
		return acc[23:16];
	endfunction

	function automatic bit gamma_apply(input led_cmd_t c, output rgbw_pkg::word_t w);
		w = '0;
		if (c.func == rgbw_pkg::FUNC_WRITE) begin
			gamma_lut[c.sel][c.idx] = c.val;
			lut_loaded[c.sel][c.idx] = 1'b1;
			return 1'b0;
		end
		if (c.sample_ok) begin
			w = {gamma_lut[rgbw_pkg::TBL_WHITE][luma_of(c.red, c.green, c.blue)],
			     gamma_lut[rgbw_pkg::TBL_BLUE][c.blue],
			     gamma_lut[rgbw_pkg::TBL_RED][c.red],
			     gamma_lut[rgbw_pkg::TBL_GREEN][c.green]};
		end
		return 1'b1;
	endfunction

	function automatic int sender_idle_pct();
		case (idle_phase)
			PH_SEND_SLOW: return 38;
			PH_RECV_SLOW: return 48;
			default:      return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (idle_phase)
			PH_SEND_SLOW: return 48;
			PH_RECV_SLOW: return 38;
			default:      return 0;
		endcase
	endfunction

	function automatic led_cmd_t random_cmd();
		led_cmd_t c;
		c.func      = rgbw_pkg::func_t'($urandom_range(1));
		c.sel       = rgbw_pkg::tbl_sel_t'($urandom_range(3));
		c.idx       = rgbw_pkg::byte_t'($urandom_range(255));
		c.val       = rgbw_pkg::byte_t'($urandom_range(255));
		c.red       = rgbw_pkg::byte_t'($urandom_range(255));
		c.green     = rgbw_pkg::byte_t'($urandom_range(255));
		c.blue      = rgbw_pkg::byte_t'($urandom_range(255));
		c.sample_ok = 1'($urandom_range(1));
		return c;
	endfunction

	function automatic rgbw_pkg::byte_t pick_channel();
		if ($urandom_range(99) < 15)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return rgbw_pkg::byte_t'($urandom_range(255));
	endfunction

	task automatic send_cmd(input led_cmd_t c, input bit typed,
	                        input rgbw_pkg::word_t typed_word);
		rgbw_pkg::word_t w;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct()) begin
			pix_in.valid = 1'b0;
			@(negedge clk);
		end
		pix_in.func         = c.func;
		pix_in.table_select = c.sel;
		pix_in.entry_index  = c.idx;
		pix_in.entry_value  = c.val;
		pix_in.red_in       = c.red;
		pix_in.green_in     = c.green;
		pix_in.blue_in      = c.blue;
		pix_in.sample_valid = c.sample_ok;
		pix_in.valid        = 1'b1;
		do @(posedge clk); while (pix_in.ready !== 1'b1);
		issued_cmds++;
		if (gamma_apply(c, w)) begin
			pending_words.push_back(typed ? typed_word : w);
			convert_beats++;
			if (!c.sample_ok)
				blank_beats++;
		end else begin
			write_beats++;
		end
	endtask

	task automatic load_entry(input rgbw_pkg::tbl_sel_t t, input rgbw_pkg::byte_t i);
		led_cmd_t c;
		c      = random_cmd();
		c.func = rgbw_pkg::FUNC_WRITE;
		c.sel  = t;
		c.idx  = i;
		send_cmd(c, 1'b0, '0);
	endtask

	initial begin
		led_cmd_t        c;
		rgbw_pkg::byte_t lut_idx [4];
		int              done_items;
		arst_n              = 1'b0;
		pix_in.valid        = 1'b0;
		pix_in.func         = rgbw_pkg::FUNC_WRITE;
		pix_in.table_select = rgbw_pkg::TBL_RED;
		pix_in.entry_index  = '0;
		pix_in.entry_value  = '0;
		pix_in.red_in       = '0;
		pix_in.green_in     = '0;
		pix_in.blue_in      = '0;
		pix_in.sample_valid = 1'b0;
		idle_phase          = PH_SEND_SLOW;
		hold_off_req        = 1'b0;
		hold_off_done       = 1'b0;
		fail_count          = 0;
		issued_cmds         = 0;
		write_beats         = 0;
		convert_beats       = 0;
		blank_beats         = 0;
		checked_words       = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			c.func      = directed_rows[i].func;
			c.sel       = directed_rows[i].sel;
			c.idx       = directed_rows[i].idx;
			c.val       = directed_rows[i].val;
			c.red       = directed_rows[i].red;
			c.green     = directed_rows[i].green;
			c.blue      = directed_rows[i].blue;
			c.sample_ok = directed_rows[i].sample_ok;
			send_cmd(c, directed_rows[i].typed, directed_rows[i].word);
		end

		while (issued_cmds < DIR_ROWS + RANDOM_ITEMS) begin
			done_items = issued_cmds - DIR_ROWS;
			if (done_items < RANDOM_ITEMS / 3) begin
				idle_phase = PH_SEND_SLOW;
			end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
				idle_phase = PH_RECV_SLOW;
			end else begin
				idle_phase   = PH_FULL_RATE;
				hold_off_req = 1'b1;
			end
			if ($urandom_range(99) < 25) begin
				load_entry(rgbw_pkg::tbl_sel_t'($urandom_range(3)),
				           rgbw_pkg::byte_t'($urandom_range(255)));
			end else begin
				c            = random_cmd();
				c.func       = rgbw_pkg::FUNC_CONVERT;
				c.red        = pick_channel();
				c.green      = pick_channel();
				c.blue       = pick_channel();
				c.sample_ok  = ($urandom_range(99) < 85);
				lut_idx[rgbw_pkg::TBL_RED]   = c.red;
				lut_idx[rgbw_pkg::TBL_GREEN] = c.green;
				lut_idx[rgbw_pkg::TBL_BLUE]  = c.blue;
				lut_idx[rgbw_pkg::TBL_WHITE] = luma_of(c.red, c.green, c.blue);
				// every entry the convert touches gets loaded first
				for (int t = 0; t < 4; t++) begin
					if (!lut_loaded[t][lut_idx[t]])
						load_entry(rgbw_pkg::tbl_sel_t'(t), lut_idx[t]);
				end
				send_cmd(c, 1'b0, '0);
			end
		end

		@(negedge clk);
		pix_in.valid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d gamma entry writes and %0d pixel converts (%0d outside the image)",
		         write_beats, convert_beats, blank_beats);
		$display("%0d LED words checked, %0d mismatches", checked_words, fail_count);
		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("rgb_to_rgbw_gamma_packer_tb OK");
		end else begin
			$display("rgb_to_rgbw_gamma_packer_tb NOT OK");
		end
		$finish;
	end

	// receiver; one long hold-off once full rate starts so the pipe backs up
	initial begin
		led_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				led_out.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
			end
			led_out.ready = ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		rgbw_pkg::word_t want;
		if (arst_n && led_out.valid === 1'b1 && led_out.ready) begin
			if (pending_words.size() == 0) begin
				$error("led_word beat with nothing expected: actual %08h", led_out.led_word);
				fail_count++;
			end else begin
				want = pending_words.pop_front();
				checked_words++;
				if (led_out.led_word !== want) begin
					$error("led_word mismatch: expected %08h actual %08h", want,
					       led_out.led_word);
					fail_count++;
				end
			end
		end
	end

	int stall_cycles = 0;

	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready === 1'b1) ||
		    (led_out.valid === 1'b1 && led_out.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles == STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d words pending", STALL_LIMIT,
				         pending_words.size());
				$display("rgb_to_rgbw_gamma_packer_tb NOT OK");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
sv/rgbw_pkg.sv
sv/rgbw_if.sv
sv/rgbw_table.sv
sv/rgbw_luma.sv
sv/rgb_to_rgbw_gamma_packer.sv
sim/rgb_to_rgbw_gamma_packer_tb.sv
